// ===== design/wmts_pkg.sv =====
package wmts_pkg;

  // Default size of the text buffer (80 columns by 23 rows)
  localparam int unsigned BUFFER_BYTES_DEF = 80 * 23;

  // Longest run of collapsed newlines
  localparam logic [1:0] NEWLINE_LIMIT = 2'd2;

  // Width of the address and length fields
  localparam int unsigned ADDR_W = 11;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_LT        = 8'h3c;
  localparam logic [7:0] CH_GT        = 8'h3e;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_LCURLY    = 8'h7b;
  localparam logic [7:0] CH_RCURLY    = 8'h7d;
  localparam logic [7:0] CH_LSQUARE   = 8'h5b;
  localparam logic [7:0] CH_RSQUARE   = 8'h5d;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CH_BAR       = 8'h7c;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_LF        = 8'h0a;

  // Signed depth limits
  localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
  localparam logic signed [7:0] DEPTH_MIN = -8'sd128;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       chunk_last;
  } in_item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [7:0]        write_char;
    logic [ADDR_W-1:0] text_length;
  } out_item_t;

  // Saturating step of a signed depth counter
  function automatic logic signed [7:0] depth_inc(input logic signed [7:0] d);
    return (d == DEPTH_MAX) ? d : d + 8'sd1;
  endfunction

  function automatic logic signed [7:0] depth_dec(input logic signed [7:0] d);
    return (d == DEPTH_MIN) ? d : d - 8'sd1;
  endfunction

  function automatic logic signed [7:0] depth_dec2(input logic signed [7:0] d);
    return (d < -8'sd126) ? DEPTH_MIN : d - 8'sd2;
  endfunction

endpackage

// ===== design/wiki_markup_text_stripper.sv =====
// A request accepted into the input register is parsed and loaded into the result
// register once that register is free; the result is then offered on the output.
// Throughput: one request per cycle while the result is not stalled; each byte needs one pass of the parse
// logic between the input register and the result register.
// A stalled result register holds while one more request waits in the input stage.
// Reset clears valids and parse state; the text position and mark restart at 0.
module wiki_markup_text_stripper import wmts_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_vld_q, in_vld_d;
  in_item_t  in_q;
  logic      out_vld_q, out_vld_d;
  out_item_t out_q;
  out_item_t res;
  logic      out_free;
  logic      adv;
  logic      acc;

  // Move the held request forward when the result register can take it
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  assign in_vld_d  = acc ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d = adv ? 1'b1 : (out_free ? 1'b0 : out_vld_q);

  wmts_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .item_i  (in_q),
    .result_o(res)
  );

  // Track valid flags of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (acc) in_q <= in_item_i;
    if (adv) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/wmts_parse.sv =====
module wmts_parse import wmts_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  localparam int unsigned PosW = $clog2(BUFFER_BYTES + 1);
  localparam logic [PosW-1:0] BufLimit = PosW'(BUFFER_BYTES);

  logic inq_q, inq_d;
  logic esc_q, esc_d;
  logic close_q, close_d;
  logic selfc_q, selfc_d;
  logic cmt_q, cmt_d;
  logic [1:0] nl_q, nl_d;
  logic signed [7:0] angle_q, angle_d;
  logic signed [7:0] curly_q, curly_d;
  logic signed [7:0] square_q, square_d;
  logic signed [7:0] markup_q, markup_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] mark_q, mark_d;

  logic [7:0] b;
  logic       vis;
  logic       wr_valid;
  logic [7:0] wr_char;
  logic       put;
  logic [7:0] put_char;

  assign b = item_i.text_byte;

  // Decode the byte and update the parse state
  always_comb begin
    inq_d    = inq_q;
    esc_d    = esc_q;
    close_d  = close_q;
    selfc_d  = selfc_q;
    cmt_d    = cmt_q;
    nl_d     = nl_q;
    angle_d  = angle_q;
    curly_d  = curly_q;
    square_d = square_q;
    markup_d = markup_q;
    pos_d    = pos_q;
    mark_d   = mark_q;
    vis      = 1'b0;
    put      = 1'b0;
    put_char = b;
    wr_valid = 1'b0;
    wr_char  = 8'd0;

    if (!esc_q && b == CH_QUOTE) begin
      inq_d = !inq_q;
      // Opening a string clears the parse state
      if (!inq_q) begin
        pos_d    = '0;
        close_d  = 1'b0;
        selfc_d  = 1'b0;
        cmt_d    = 1'b0;
        nl_d     = NEWLINE_LIMIT;
        angle_d  = '0;
        curly_d  = '0;
        square_d = '0;
        markup_d = '0;
      end
    end else if (inq_q) begin
      unique case (b)
        CH_BACKSLASH: esc_d = 1'b1;
        CH_LT: begin
          angle_d  = depth_inc(angle_q);
          close_d  = 1'b1;
          markup_d = depth_inc(markup_q);
        end
        CH_GT: begin
          angle_d = depth_dec(angle_q);
          if (selfc_q || cmt_q) markup_d = depth_dec(markup_q);
          cmt_d = 1'b0;
        end
        CH_SLASH: begin
          if (angle_q == 8'sd1) begin
            if (close_q) markup_d = depth_dec2(markup_q);
            else selfc_d = 1'b1;
          end else begin
            vis = 1'b1;
          end
        end
        CH_BANG: begin
          if (angle_q == 8'sd1 && close_q) cmt_d = 1'b1;
          else vis = 1'b1;
        end
        CH_LCURLY: curly_d = depth_inc(curly_q);
        CH_RCURLY: curly_d = depth_dec(curly_q);
        CH_LSQUARE: begin
          square_d = depth_inc(square_q);
          mark_d   = pos_q;
        end
        CH_RSQUARE: square_d = depth_dec(square_q);
        CH_APOS: ;
        CH_BAR: begin
          if (square_q != 8'sd0) pos_d = mark_q;
        end
        default: vis = 1'b1;
      endcase
    end

    // Visible character: write unless inside markup, collapse escaped newlines
    if (vis) begin
      if (markup_q == 8'sd0 && angle_q == 8'sd0 && curly_q == 8'sd0) begin
        if (esc_q && b == CH_N) begin
          if (nl_q < NEWLINE_LIMIT) begin
            put      = 1'b1;
            put_char = CH_LF;
            nl_d     = nl_q + 2'd1;
          end
        end else begin
          put  = 1'b1;
          nl_d = 2'd0;
        end
      end
      esc_d   = 1'b0;
      close_d = 1'b0;
      selfc_d = 1'b0;
    end

    // Drop writes once the buffer is full
    if (put && pos_q < BufLimit) begin
      wr_valid = 1'b1;
      wr_char  = put_char;
      pos_d    = pos_q + 1'b1;
    end
  end

  // Build the result for this byte
  always_comb begin
    result_o.write_valid = wr_valid;
    result_o.write_addr  = wr_valid ? ADDR_W'(pos_q) : '0;
    result_o.write_char  = wr_char;
    result_o.text_length = ADDR_W'(pos_d);
  end

  // Hold the parse state between bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_q    <= 1'b0;
      esc_q    <= 1'b0;
      close_q  <= 1'b0;
      selfc_q  <= 1'b0;
      cmt_q    <= 1'b0;
      nl_q     <= NEWLINE_LIMIT;
      angle_q  <= '0;
      curly_q  <= '0;
      square_q <= '0;
      markup_q <= '0;
      pos_q    <= '0;
      mark_q   <= '0;
    end else if (step_i) begin
      inq_q    <= inq_d;
      esc_q    <= esc_d;
      close_q  <= close_d;
      selfc_q  <= selfc_d;
      cmt_q    <= cmt_d;
      nl_q     <= nl_d;
      angle_q  <= angle_d;
      curly_q  <= curly_d;
      square_q <= square_d;
      markup_q <= markup_d;
      pos_q    <= pos_d;
      mark_q   <= mark_d;
    end
  end

  a_nl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_q <= NEWLINE_LIMIT) else $error("newline run out of range");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= BufLimit && mark_q <= BufLimit) else $error("position beyond buffer");

  a_write_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && wr_valid |-> inq_q) else $error("write outside a string");

  a_write_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && wr_valid |=> pos_q == $past(pos_q) + 1'b1)
    else $error("write did not advance position");

endmodule

// ===== test/wiki_markup_text_stripper_tb.sv =====
`timescale 1ns / 100ps

module wiki_markup_text_stripper_tb import wmts_pkg::*;;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 900;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  wiki_markup_text_stripper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  // Expected buffer writes and text lengths, oldest first
  out_item_t strip_q[$];
  int        errors = 0;
  int        sent_count = 0;

  // Sender burst control
  bit gaps_on = 1'b0;
  int burst_left = 0;

  // Receiver hold-off request, toggled by the tests
  bit hold_req = 1'b0;

  // Stripper state as the testbench tracks it
  logic               in_string;
  logic               esc_pending;
  logic               close_mark;
  logic               self_close;
  logic               comment_mark;
  logic [1:0]         lf_run;
  logic signed [7:0]  angle_d;
  logic signed [7:0]  curly_d;
  logic signed [7:0]  square_d;
  logic signed [7:0]  tag_d;
  logic [ADDR_W-1:0]  text_pos;
  logic [ADDR_W-1:0]  bracket_pos;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamp to the signed 8-bit range
  function automatic logic signed [7:0] clamp8(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return v[7:0];
  endfunction

  function automatic void clear_parse_state();
    text_pos     = '0;
    close_mark   = 1'b0;
    self_close   = 1'b0;
    comment_mark = 1'b0;
    lf_run       = NEWLINE_LIMIT;
    angle_d      = '0;
    curly_d      = '0;
    square_d     = '0;
    tag_d        = '0;
  endfunction

  function automatic void put_char(input logic [7:0] c, inout out_item_t res);
    if (text_pos < BUFFER_BYTES_DEF) begin
      res.write_valid = 1'b1;
      res.write_addr  = text_pos;
      res.write_char  = c;
      text_pos++;
    end
  endfunction

  // Write a visible character unless inside markup; drop the pending marks
  function automatic void show_char(input logic [7:0] c, inout out_item_t res);
    if (tag_d == 0 && angle_d == 0 && curly_d == 0) begin
      if (esc_pending && c == CH_N) begin
        if (lf_run < NEWLINE_LIMIT) begin
          put_char(CH_LF, res);
          lf_run++;
        end
      end else begin
        put_char(c, res);
        lf_run = '0;
      end
    end
    esc_pending = 1'b0;
    close_mark  = 1'b0;
    self_close  = 1'b0;
  endfunction

  // Advance the tracked state by one byte and return the expected result
  function automatic out_item_t strip_byte(input in_item_t item);
    out_item_t  res;
    logic [7:0] b;
    res = '0;
    b = item.text_byte;
    if (!esc_pending && b == CH_QUOTE) begin
      in_string = !in_string;
      if (in_string) clear_parse_state();
    end else if (in_string) begin
      case (b)
        CH_BACKSLASH: esc_pending = 1'b1;
        CH_LT: begin
          angle_d    = clamp8(angle_d + 1);
          close_mark = 1'b1;
          tag_d      = clamp8(tag_d + 1);
        end
        CH_GT: begin
          angle_d = clamp8(angle_d - 1);
          if (self_close || comment_mark) tag_d = clamp8(tag_d - 1);
          comment_mark = 1'b0;
        end
        CH_SLASH: begin
          if (angle_d == 1) begin
            if (close_mark) tag_d = clamp8(tag_d - 2);
            else self_close = 1'b1;
          end else begin
            show_char(b, res);
          end
        end
        CH_BANG: begin
          if (angle_d == 1 && close_mark) comment_mark = 1'b1;
          else show_char(b, res);
        end
        CH_LCURLY:  curly_d = clamp8(curly_d + 1);
        CH_RCURLY:  curly_d = clamp8(curly_d - 1);
        CH_LSQUARE: begin
          square_d    = clamp8(square_d + 1);
          bracket_pos = text_pos;
        end
        CH_RSQUARE: square_d = clamp8(square_d - 1);
        CH_APOS: ;
        CH_BAR: begin
          if (square_d != 0) text_pos = bracket_pos;
        end
        default: show_char(b, res);
      endcase
    end
    res.text_length = text_pos;
    return res;
  endfunction

  // Offer one request, hold it until accepted, then maybe pause
  task automatic send_byte(input logic [7:0] b);
    in_item_t item;
    int       gap;
    item.text_byte  = b;
    item.chunk_last = 1'($urandom_range(0, 1));
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    strip_q.push_back(strip_byte(item));
    sent_count++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
        gap = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_repeat(input string s, input int n);
    repeat (n) send_text(s);
  endtask

  task automatic send_word();
    int len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(65, 90)));
      else send_byte(8'($urandom_range(97, 122)));
    end
  endtask

  // Open a fresh string so the parse state starts clean
  task automatic enter_string();
    if (esc_pending) send_text("x");
    if (in_string) send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
  endtask

  // Stop offering and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    while (strip_q.size() != 0) @(posedge clk_i);
  endtask

  // One piece of page text: mostly well-formed markup, sometimes noise
  task automatic send_fragment();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_word();
    end else if (r < 33) begin
      send_text(" ");
    end else if (r < 41) begin
      send_repeat("\\n", $urandom_range(1, 4));
    end else if (r < 48) begin
      send_byte(CH_LT);
      send_word();
      send_byte(CH_GT);
    end else if (r < 54) begin
      send_text("</");
      send_word();
      send_byte(CH_GT);
    end else if (r < 58) begin
      send_text("<br/>");
    end else if (r < 62) begin
      send_text("<!--");
      send_word();
      send_text("-->");
    end else if (r < 71) begin
      send_text("[[");
      send_word();
      if ($urandom_range(0, 1) == 1) begin
        send_byte(CH_BAR);
        send_word();
      end
      send_text("]]");
    end else if (r < 76) begin
      send_text("{{");
      send_word();
      send_text("}}");
    end else if (r < 79) begin
      send_text("\\\"");
    end else if (r < 83) begin
      send_text("''");
      send_word();
      send_text("''");
    end else if (r < 86) begin
      send_byte(CH_QUOTE);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_QUOTE);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Byte extremes, newline collapse, escapes, marks, tags and comments
  task automatic test_directed();
    enter_string();
    send_byte(8'h00);
    send_byte(8'hff);
    // rewind while no mark was taken since reset
    send_text("]|[");
    send_text("\\n\\n\\n");
    // escape survives the bracket, then rewind to the mark
    send_text("\\[n|]");
    send_text("<br/>");
    send_text("<!x>");
    send_text("a/!{y}'");
    send_text("\\\"");
    // close the string, ignore a byte outside, reopen
    send_text("\"z\"");
    drain();
  endtask

  // Drive every depth counter into both saturation limits
  task automatic test_depth_limits();
    enter_string();
    send_repeat("<", 130);
    send_repeat(">", 260);
    send_text("v");
    enter_string();
    send_repeat("{", 130);
    send_repeat("}", 260);
    send_text("w");
    enter_string();
    send_repeat("[", 130);
    send_repeat("]", 260);
    send_text("k|");
    enter_string();
    send_repeat("</>", 130);
    send_text("m");
    drain();
  endtask

  // Offer more characters than the buffer holds
  task automatic test_buffer_full();
    gaps_on = 1'b1;
    enter_string();
    repeat (BUFFER_BYTES_DEF + 6) send_byte(8'($urandom_range(97, 122)));
    send_text("\\n");
    drain();
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    int start;
    gaps_on = 1'b0;
    enter_string();
    hold_req = ~hold_req;
    start = sent_count;
    while (sent_count < start + 40) send_fragment();
    drain();
  endtask

  task automatic test_random();
    int start;
    gaps_on = 1'b1;
    enter_string();
    start = sent_count;
    while (sent_count < start + RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) enter_string();
      send_fragment();
    end
    drain();
  endtask

  // Receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    static bit hold_ack = 1'b0;
    static int hold_left = 0;
    static int stall_pct = 0;
    static int phase_left = 0;
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (phase_left == 0) begin
      case ($urandom_range(0, 3))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 25;
        default: stall_pct = 70;
      endcase
      phase_left = $urandom_range(20, 80);
    end else begin
      phase_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (strip_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = strip_q.pop_front();
        if (out_item.write_valid !== want.write_valid) begin
          $error("write_valid: expected %0d, got %0d", want.write_valid, out_item.write_valid);
          errors++;
        end
        if (out_item.write_addr !== want.write_addr) begin
          $error("write_addr: expected %0d, got %0d", want.write_addr, out_item.write_addr);
          errors++;
        end
        if (out_item.write_char !== want.write_char) begin
          $error("write_char: expected %0d, got %0d", want.write_char, out_item.write_char);
          errors++;
        end
        if (out_item.text_length !== want.text_length) begin
          $error("text_length: expected %0d, got %0d", want.text_length, out_item.text_length);
          errors++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    static int idle_cycles = 0;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("wiki_markup_text_stripper_tb: done, errors");
      $finish;
    end
  end

  initial begin
    in_string   = 1'b0;
    esc_pending = 1'b0;
    bracket_pos = '0;
    clear_parse_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_depth_limits();
    test_buffer_full();
    test_backpressure();
    test_random();
    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("wiki_markup_text_stripper_tb: done, clean");
    end else begin
      $display("wiki_markup_text_stripper_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wmts_pkg.sv
design/wmts_parse.sv
design/wiki_markup_text_stripper.sv
test/wiki_markup_text_stripper_tb.sv
